@@ rtl/core/psbs_pkg.sv @@
package psbs_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned MAX_BUCKETS_DEF = 1024;
    localparam int unsigned SIZE_BITS_DEF   = 16;

    // Fixed field widths.
    localparam int unsigned OPCODE_W      = 1;
    localparam int unsigned BUCKET_SIZE_W = 16;
    localparam int unsigned LABEL_W       = 26;
    localparam int unsigned TOTAL_W       = 26;
    localparam int unsigned INDEX_W       = 11;

    // Request opcodes.
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // Commands from the sequencer to the search unit.
    typedef struct packed {
        logic start;
        logic step;
    } search_ctrl_t;

    // Status from the search unit back to the sequencer.
    typedef struct packed {
        logic more;
        logic rd_en;
    } search_stat_t;

endpackage

@@ rtl/core/psbs_ram.sv @@
module psbs_ram #(
    parameter int unsigned WIDTH = 26,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/psbs_search_unit.sv @@
module psbs_search_unit #(
    parameter int unsigned MAX_BUCKETS = psbs_pkg::MAX_BUCKETS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  psbs_pkg::search_ctrl_t              ctrl,
    input  logic [$clog2(MAX_BUCKETS+1)-1:0]    count,
    input  logic [psbs_pkg::LABEL_W-1:0]        label,
    input  logic [psbs_pkg::TOTAL_W-1:0]        rd_data,
    output logic [$clog2(MAX_BUCKETS)-1:0]      rd_addr,
    output psbs_pkg::search_stat_t              stat,
    output logic [$clog2(MAX_BUCKETS+1)-1:0]    pos
);

    localparam int unsigned CNT_W  = $clog2(MAX_BUCKETS + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_BUCKETS);

    logic [CNT_W-1:0]             lo_reg, lo_next;
    logic [CNT_W-1:0]             hi_reg, hi_next;
    logic [CNT_W-1:0]             mid_reg, mid_next;
    logic [psbs_pkg::LABEL_W-1:0] label_reg, label_next;
    logic                         below;

    // The single comparator: is the entry read last cycle below the label?
    assign below = (rd_data < label_reg);

    always_comb begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        label_next = label_reg;
        if (ctrl.start) begin
            lo_next    = '0;
            hi_next    = count;
            label_next = label;
        end else if (ctrl.step) begin
            if (below) begin
                lo_next = mid_reg + CNT_W'(1);
            end else begin
                hi_next = mid_reg;
            end
        end
        // The next probe address goes straight to the table so that one
        // halving step completes every cycle.
        mid_next   = lo_next + ((hi_next - lo_next) >> 1);
        stat.more  = (lo_next < hi_next);
        stat.rd_en = (ctrl.start || ctrl.step) && stat.more;
    end

    assign rd_addr = mid_next[ADDR_W-1:0];
    assign pos     = lo_reg;

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        label_reg <= label_next;
    end

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.step |-> (lo_reg < hi_reg))
        else $error("search step issued with an empty interval");

endmodule

@@ rtl/core/prefix_sum_bucket_search_top.sv @@
// Running-sum table with a lower-bound search. A load request (opcode 0)
// adds its bucket size to the running total, saturating at 2^26-1, and
// stores the total in the next table slot; it gives no result, and loads
// beyond MAX_BUCKETS are dropped. A query request (opcode 1) returns the
// 1-based index of the first bucket whose running sum is at least the
// label, or count+1 with found low. A query holds off the input while it
// runs: the request is taken, then the halving steps follow, each set by
// the single read port of the sum table and the one comparator that judges
// each probe, and then the result is posted, later only while an earlier
// result still waits in the output register. The result sits in an
// output register, so loads are still taken while it waits to be read.
module prefix_sum_bucket_search_top #(
    parameter int unsigned MAX_BUCKETS = psbs_pkg::MAX_BUCKETS_DEF,
    parameter int unsigned SIZE_BITS   = psbs_pkg::SIZE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [psbs_pkg::OPCODE_W-1:0]       s_opcode,
    input  logic [psbs_pkg::BUCKET_SIZE_W-1:0]  s_bucket_size,
    input  logic [psbs_pkg::LABEL_W-1:0]        s_label,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [psbs_pkg::INDEX_W-1:0]        m_bucket_index,
    output logic                                m_found
);

    localparam int unsigned CNT_W     = $clog2(MAX_BUCKETS + 1);
    localparam int unsigned ADDR_W    = $clog2(MAX_BUCKETS);
    localparam int unsigned IDX_EXT_W = (CNT_W + 1 > psbs_pkg::INDEX_W) ?
                                        CNT_W + 1 : psbs_pkg::INDEX_W;
    localparam logic [63:0] SIZE_MASK = (64'd1 << SIZE_BITS) - 64'd1;

    psbs_pkg::state_t       state_reg, state_next;
    psbs_pkg::search_ctrl_t ctrl;
    psbs_pkg::search_stat_t stat;

    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [psbs_pkg::TOTAL_W-1:0]      total_reg, total_next;
    logic [psbs_pkg::TOTAL_W:0]        sum_wide;
    logic [psbs_pkg::BUCKET_SIZE_W-1:0] size_masked;
    logic                              accept;
    logic                              load_we;
    logic                              full;

    logic [psbs_pkg::TOTAL_W-1:0]      rd_data;
    logic [ADDR_W-1:0]                 rd_addr;
    logic [CNT_W-1:0]                  pos;
    logic [IDX_EXT_W-1:0]              idx_ext;

    logic                              m_valid_reg, m_valid_next;
    logic [psbs_pkg::INDEX_W-1:0]      index_reg, index_next;
    logic                              found_reg, found_next;

    assign accept      = s_valid && s_ready;
    assign full        = (count_reg == CNT_W'(MAX_BUCKETS));
    assign size_masked = s_bucket_size & SIZE_MASK[psbs_pkg::BUCKET_SIZE_W-1:0];
    assign sum_wide    = {1'b0, total_reg} + (psbs_pkg::TOTAL_W + 1)'(size_masked);
    assign load_we     = accept && (s_opcode == psbs_pkg::OP_LOAD) && !full;

    always_comb begin
        count_next = count_reg;
        total_next = total_reg;
        if (load_we) begin
            count_next = count_reg + CNT_W'(1);
            total_next = sum_wide[psbs_pkg::TOTAL_W] ? '1 :
                         sum_wide[psbs_pkg::TOTAL_W-1:0];
        end
    end

    assign idx_ext = IDX_EXT_W'(pos) + IDX_EXT_W'(1);

    always_comb begin
        state_next   = state_reg;
        ctrl.start   = 1'b0;
        ctrl.step    = 1'b0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        index_next   = index_reg;
        found_next   = found_reg;
        unique case (state_reg)
            psbs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept && (s_opcode == psbs_pkg::OP_QUERY)) begin
                    ctrl.start = 1'b1;
                    state_next = stat.more ? psbs_pkg::ST_SEARCH : psbs_pkg::ST_DONE;
                end
            end
            psbs_pkg::ST_SEARCH: begin
                ctrl.step = 1'b1;
                if (!stat.more) begin
                    state_next = psbs_pkg::ST_DONE;
                end
            end
            psbs_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    index_next   = idx_ext[psbs_pkg::INDEX_W-1:0];
                    found_next   = (pos < count_reg);
                    state_next   = psbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = psbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= psbs_pkg::ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        index_reg <= index_next;
        found_reg <= found_next;
    end

    psbs_ram #(
        .WIDTH (psbs_pkg::TOTAL_W),
        .DEPTH (MAX_BUCKETS)
    ) u_sum_table (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (total_next),
        .re    (stat.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    psbs_search_unit #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .count   (count_reg),
        .label   (s_label),
        .rd_data (rd_data),
        .rd_addr (rd_addr),
        .stat    (stat),
        .pos     (pos)
    );

    assign m_valid        = m_valid_reg;
    assign m_bucket_index = index_reg;
    assign m_found        = found_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BUCKETS))
        else $error("bucket count exceeds table depth");

    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        load_we |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted load did not advance the bucket count");

    a_total_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned RANDOM_REQUESTS = 1580;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [psbs_pkg::OPCODE_W-1:0]      s_opcode;
    logic [psbs_pkg::BUCKET_SIZE_W-1:0] s_bucket_size;
    logic [psbs_pkg::LABEL_W-1:0]       s_label;
    logic                               m_valid;
    logic                               m_ready;
    logic [psbs_pkg::INDEX_W-1:0]       m_bucket_index;
    logic                               m_found;

    // Set during one stretch of the run so that neither side idles.
    bit calm;

    typedef struct packed {
        logic [psbs_pkg::INDEX_W-1:0] index;
        logic                         found;
    } lookup_t;

    class search_scoreboard;
        logic [psbs_pkg::TOTAL_W-1:0] run_sums [psbs_pkg::MAX_BUCKETS_DEF];
        int unsigned                  loaded;
        logic [psbs_pkg::TOTAL_W-1:0] total;
        lookup_t                      awaited[$];
        int unsigned                  mismatches;

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endfunction

        function void note_request(logic [psbs_pkg::OPCODE_W-1:0] op,
                                   logic [psbs_pkg::BUCKET_SIZE_W-1:0] sz,
                                   logic [psbs_pkg::LABEL_W-1:0] lb);
            logic [psbs_pkg::TOTAL_W:0] wide;
            int unsigned                pos;
            lookup_t                    ans;
            if (op == psbs_pkg::OP_LOAD) begin
                // A load into a full table is dropped without a trace.
                if (loaded < psbs_pkg::MAX_BUCKETS_DEF) begin
                    wide = {1'b0, total} + sz;
                    if (wide[psbs_pkg::TOTAL_W]) begin
                        wide = {1'b0, {psbs_pkg::TOTAL_W{1'b1}}};
                    end
                    total = wide[psbs_pkg::TOTAL_W-1:0];
                    run_sums[loaded] = total;
                    loaded++;
                end
            end else begin
                // The sums never decrease, so a plain scan finds the lower bound.
                pos = 0;
                while (pos < loaded && run_sums[pos] < psbs_pkg::TOTAL_W'(lb)) begin
                    pos++;
                end
                ans.index = psbs_pkg::INDEX_W'(pos + 1);
                ans.found = (pos < loaded);
                awaited.push_back(ans);
            end
        endfunction

        function void check_result(logic [psbs_pkg::INDEX_W-1:0] index, logic found);
            lookup_t want;
            if (awaited.size() == 0) begin
                flag($sformatf("unexpected result index=%0d found=%0b", index, found));
            end else begin
                want = awaited.pop_front();
                if (index !== want.index || found !== want.found) begin
                    flag($sformatf("expected index=%0d found=%0b, got index=%0d found=%0b",
                                   want.index, want.found, index, found));
                end
            end
        endfunction
    endclass

    search_scoreboard sb;

    prefix_sum_bucket_search_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_bucket_size  (s_bucket_size),
        .s_label        (s_label),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index),
        .m_found        (m_found)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    task automatic send_request(input logic [psbs_pkg::OPCODE_W-1:0] op,
                                input logic [psbs_pkg::BUCKET_SIZE_W-1:0] sz,
                                input logic [psbs_pkg::LABEL_W-1:0] lb);
        while (!calm && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_bucket_size <= sz;
        s_label       <= lb;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.note_request(op, sz, lb);
    endtask

    // Result side: random back-pressure and checking of every accepted result.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_bucket_index, m_found);
        end
        m_ready <= calm || ($urandom_range(0, 99) >= 29);
    end

    int unsigned quiet_cycles;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("[prefix_sum_bucket_search_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [psbs_pkg::BUCKET_SIZE_W-1:0] sz;
        logic [psbs_pkg::LABEL_W-1:0]       lb;
        logic [psbs_pkg::TOTAL_W-1:0]       near;
        int unsigned                        load_pct;
        int unsigned                        pick;

        sb = new;
        calm = 1'b0;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_opcode      <= psbs_pkg::OP_LOAD;
        s_bucket_size <= '0;
        s_label       <= '0;
        m_ready       <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Queries on the empty table.
        send_request(psbs_pkg::OP_QUERY, '1, '0);
        send_request(psbs_pkg::OP_QUERY, '0, '1);
        // Extreme sizes, with zero sizes giving repeated sums; the unused label is set.
        send_request(psbs_pkg::OP_LOAD, '0, '1);
        send_request(psbs_pkg::OP_LOAD, '1, '0);
        send_request(psbs_pkg::OP_LOAD, psbs_pkg::BUCKET_SIZE_W'(1), '1);
        send_request(psbs_pkg::OP_LOAD, '0, psbs_pkg::LABEL_W'(12345));
        send_request(psbs_pkg::OP_LOAD, '1, '0);
        // Label zero, exact sums, the first of equal sums, and labels past the total.
        send_request(psbs_pkg::OP_QUERY, '0, '0);
        send_request(psbs_pkg::OP_QUERY, '1, psbs_pkg::LABEL_W'(1));
        send_request(psbs_pkg::OP_QUERY, '0, psbs_pkg::LABEL_W'(65535));
        send_request(psbs_pkg::OP_QUERY, '0, psbs_pkg::LABEL_W'(65536));
        send_request(psbs_pkg::OP_QUERY, '0, psbs_pkg::LABEL_W'(65537));
        send_request(psbs_pkg::OP_QUERY, '0, psbs_pkg::LABEL_W'(131071));
        send_request(psbs_pkg::OP_QUERY, '0, psbs_pkg::LABEL_W'(131072));
        send_request(psbs_pkg::OP_QUERY, '1, '1);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            calm = (n >= 500 && n < 700);
            // Loads dominate until the table fills; after that they exercise the drop.
            load_pct = (sb.loaded < psbs_pkg::MAX_BUCKETS_DEF) ? 80 : 35;
            if ($urandom_range(0, 99) < load_pct) begin
                case ($urandom_range(0, 9))
                    0: sz = '0;
                    1: sz = '1;
                    2: sz = psbs_pkg::BUCKET_SIZE_W'($urandom_range(0, 15));
                    default: sz = psbs_pkg::BUCKET_SIZE_W'($urandom);
                endcase
                send_request(psbs_pkg::OP_LOAD, sz, psbs_pkg::LABEL_W'($urandom));
            end else begin
                if (sb.loaded == 0) begin
                    near = '0;
                end else begin
                    pick = $urandom_range(0, sb.loaded - 1);
                    near = sb.run_sums[pick];
                end
                case ($urandom_range(0, 9))
                    0: lb = '0;
                    1: lb = psbs_pkg::LABEL_W'(sb.total);
                    2: lb = psbs_pkg::LABEL_W'(sb.total + 1);
                    3, 4: lb = psbs_pkg::LABEL_W'(near);
                    5: lb = psbs_pkg::LABEL_W'(near + 1);
                    6: lb = psbs_pkg::LABEL_W'(near - 1);
                    7, 8: lb = psbs_pkg::LABEL_W'($urandom_range(0, sb.total));
                    default: lb = psbs_pkg::LABEL_W'($urandom);
                endcase
                send_request(psbs_pkg::OP_QUERY, psbs_pkg::BUCKET_SIZE_W'($urandom), lb);
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (sb.awaited.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("[prefix_sum_bucket_search_top] OK");
        end else begin
            $display("[prefix_sum_bucket_search_top] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/psbs_pkg.sv
rtl/core/psbs_ram.sv
rtl/core/psbs_search_unit.sv
rtl/core/prefix_sum_bucket_search_top.sv
tb/tb_top.sv
